>>> rtl/core/peu_pkg.sv
// Package for the particle Euler update: word types, register indexes, Q16.16 helpers.
package peu_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_TIME_STEP = 3'd0;
   localparam logic [2:0] CSR_GRAVITY_X = 3'd1;
   localparam logic [2:0] CSR_GRAVITY_Y = 3'd2;
   localparam logic [2:0] CSR_GRAVITY_Z = 3'd3;
   localparam logic [2:0] CSR_DRAG_RATE = 3'd4;
   localparam logic [2:0] CSR_SPIN_RATE = 3'd5;

   localparam logic [30:0] TIME_STEP_RESET = 31'd1092;
   localparam int AXES = 3;

   // Input word: one particle record
   typedef struct packed {
      logic [30:0]        age_in;
      logic [30:0]        life_span;
      logic signed [31:0] pos_x_in;
      logic signed [31:0] pos_y_in;
      logic signed [31:0] pos_z_in;
      logic signed [31:0] vel_x_in;
      logic signed [31:0] vel_y_in;
      logic signed [31:0] vel_z_in;
      logic signed [31:0] angle_in;
      logic               alive_in;
   } req_word_type;

   // Result word: the record one frame later
   typedef struct packed {
      logic               alive_out;
      logic [30:0]        age_out;
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic signed [31:0] pos_z_out;
      logic signed [31:0] vel_x_out;
      logic signed [31:0] vel_y_out;
      logic signed [31:0] vel_z_out;
      logic signed [31:0] angle_out;
   } rsp_word_type;

   // Q16.16 rescale of an exact product, rounding half up: floor((p + 0x8000) / 2^16)
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] sum;
      sum = p + 64'sh8000;
      return sum[63:16];
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -49'sh0_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/particle_euler_update.sv
// Top level: pipelined explicit Euler step for one particle record per word.
// A word passes the five register stages and then the output register before it shows on rsp_valid.
// Throughput: one word per cycle while req_stall is low; the pipeline holds while the
// one-word skid behind the output register is full, and req_stall rises only then.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: time_step 1092, all others 0.
module particle_euler_update (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  peu_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output peu_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import peu_pkg::*;

   // Configuration registers
   logic [30:0]        time_step_ff;
   logic signed [31:0] gravity_ff [AXES];
   logic [30:0]        drag_rate_ff;
   logic signed [31:0] spin_rate_ff;
   logic signed [31:0] dt_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         gravity_ff[0] <= '0;
         gravity_ff[1] <= '0;
         gravity_ff[2] <= '0;
         drag_rate_ff <= '0;
         spin_rate_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata[30:0];
            CSR_GRAVITY_X: gravity_ff[0] <= csr_wdata;
            CSR_GRAVITY_Y: gravity_ff[1] <= csr_wdata;
            CSR_GRAVITY_Z: gravity_ff[2] <= csr_wdata;
            CSR_DRAG_RATE: drag_rate_ff <= csr_wdata[30:0];
            CSR_SPIN_RATE: spin_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dt_s = $signed({1'b0, time_step_ff});

   // Pipeline enable: everything moves while the skid slot is free
   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;
   rsp_word_type skid_data_ff, skid_data_in;
   rsp_word_type out_data_ff, out_data_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Valid bits of the five stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Pass-through record fields, carried along every stage
   logic signed [31:0] pos_ff [5][AXES];
   logic signed [31:0] vel_ff [5][AXES];
   logic signed [31:0] angle_ff [5];
   logic [30:0]        age_ff [5];
   logic               upd_ff [5];

   // Stage 1: age update, death test, config products
   logic [31:0]        age_sum;
   logic [30:0]        new_age;
   logic               upd_s1;
   logic signed [63:0] s1_pg_ff [AXES];
   logic signed [63:0] s1_pd_ff;
   logic signed [63:0] s1_ps_ff;

   always_comb begin
      age_sum = {1'b0, req_data.age_in} + {1'b0, time_step_ff};
      new_age = age_sum[31] ? 31'h7FFF_FFFF : age_sum[30:0];
      upd_s1  = req_data.alive_in && (new_age < req_data.life_span);
   end

   // Stage 2: gravity into velocity, drag factor, new angle
   logic signed [31:0] s2_vg_ff [AXES];
   logic signed [31:0] s2_fac_ff;
   logic signed [31:0] s2_ang_ff;
   logic signed [47:0] r_d, r_s;
   logic signed [47:0] r_g [AXES];
   logic signed [31:0] vg_in [AXES];
   logic signed [31:0] fac_in, ang_in;

   always_comb begin
      r_d    = round_q16(s1_pd_ff);
      r_s    = round_q16(s1_ps_ff);
      fac_in = sat32(49'sd65536 - {r_d[47], r_d});
      ang_in = sat32({{17{angle_ff[0][31]}}, angle_ff[0]} + {r_s[47], r_s});
      for (int i = 0; i < AXES; i++) begin
         r_g[i]   = round_q16(s1_pg_ff[i]);
         vg_in[i] = sat32({{17{vel_ff[0][i][31]}}, vel_ff[0][i]} + {r_g[i][47], r_g[i]});
      end
   end

   // Stage 3: velocity times drag factor
   logic signed [63:0] s3_pv_ff [AXES];
   logic signed [31:0] s3_ang_ff;

   // Stage 4: rounded new velocity
   logic signed [31:0] s4_v_ff [AXES];
   logic signed [31:0] s4_ang_ff;
   logic signed [47:0] r_v [AXES];
   logic signed [31:0] v_in [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         r_v[i]  = round_q16(s3_pv_ff[i]);
         v_in[i] = sat32({r_v[i][47], r_v[i]});
      end
   end

   // Stage 5: velocity times dt
   logic signed [63:0] s5_pp_ff [AXES];
   logic signed [31:0] s5_v_ff [AXES];
   logic signed [31:0] s5_ang_ff;

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         pos_ff[0][0] <= req_data.pos_x_in;
         pos_ff[0][1] <= req_data.pos_y_in;
         pos_ff[0][2] <= req_data.pos_z_in;
         vel_ff[0][0] <= req_data.vel_x_in;
         vel_ff[0][1] <= req_data.vel_y_in;
         vel_ff[0][2] <= req_data.vel_z_in;
         angle_ff[0]  <= req_data.angle_in;
         age_ff[0]    <= req_data.alive_in ? new_age : req_data.age_in;
         upd_ff[0]    <= upd_s1;
         for (int i = 0; i < AXES; i++) begin
            s1_pg_ff[i] <= gravity_ff[i] * dt_s;
         end
         s1_pd_ff <= $signed({1'b0, drag_rate_ff}) * dt_s;
         s1_ps_ff <= spin_rate_ff * dt_s;
         // carry stages 2 to 5
         for (int s = 1; s < 5; s++) begin
            pos_ff[s]   <= pos_ff[s-1];
            vel_ff[s]   <= vel_ff[s-1];
            angle_ff[s] <= angle_ff[s-1];
            age_ff[s]   <= age_ff[s-1];
            upd_ff[s]   <= upd_ff[s-1];
         end
         // stage 2
         s2_vg_ff  <= vg_in;
         s2_fac_ff <= fac_in;
         s2_ang_ff <= ang_in;
         // stage 3
         for (int i = 0; i < AXES; i++) begin
            s3_pv_ff[i] <= s2_vg_ff[i] * s2_fac_ff;
         end
         s3_ang_ff <= s2_ang_ff;
         // stage 4
         s4_v_ff   <= v_in;
         s4_ang_ff <= s3_ang_ff;
         // stage 5
         for (int i = 0; i < AXES; i++) begin
            s5_pp_ff[i] <= s4_v_ff[i] * dt_s;
         end
         s5_v_ff   <= s4_v_ff;
         s5_ang_ff <= s4_ang_ff;
      end
   end

   // Final add into position and choice between update and pass-through
   logic signed [47:0] r_p [AXES];
   logic signed [31:0] p_new [AXES];
   rsp_word_type       res;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         r_p[i]   = round_q16(s5_pp_ff[i]);
         p_new[i] = sat32({{17{pos_ff[4][i][31]}}, pos_ff[4][i]} + {r_p[i][47], r_p[i]});
      end
      res.alive_out = upd_ff[4];
      res.age_out   = age_ff[4];
      res.pos_x_out = upd_ff[4] ? p_new[0]   : pos_ff[4][0];
      res.pos_y_out = upd_ff[4] ? p_new[1]   : pos_ff[4][1];
      res.pos_z_out = upd_ff[4] ? p_new[2]   : pos_ff[4][2];
      res.vel_x_out = upd_ff[4] ? s5_v_ff[0] : vel_ff[4][0];
      res.vel_y_out = upd_ff[4] ? s5_v_ff[1] : vel_ff[4][1];
      res.vel_z_out = upd_ff[4] ? s5_v_ff[2] : vel_ff[4][2];
      res.angle_out = upd_ff[4] ? s5_ang_ff  : angle_ff[4];
   end

   // Output register with one-word skid
   logic push, pop;

   always_comb begin
      push          = en && v5_ff;
      pop           = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // skid only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output register is empty");

   // skid fills only when the output was stalled
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall && v5_ff))
      else $error("skid filled without a stalled output");

   // a drained skid word moves into the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid word lost on drain");

   // a record with saturated age never comes out alive
   a_alive_only_updated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.alive_out) |-> (rsp_data.age_out != 31'h7FFF_FFFF))
      else $error("saturated age reported alive");
`endif

endmodule
